/* src/tsp_pkg.sv */
package tsp_pkg;

  localparam int unsigned SpeedW = 12;
  localparam int unsigned DistW  = 30;
  localparam int unsigned CfgIdxW = 2;
  // The squared speed difference is below 2^24, so a larger remaining distance never brakes.
  localparam int unsigned SqW    = 2 * SpeedW;
  localparam int unsigned DivW   = SpeedW + 1;
  localparam int unsigned ProdW  = SqW + DivW;

  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  typedef enum logic [1:0] {
    PH_RIDE  = 2'd0,
    PH_BRAKE = 2'd1,
    PH_STOP  = 2'd2
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CRUISE = 2'd0,
    CFG_END    = 2'd1,
    CFG_ACCEL  = 2'd2,
    CFG_TARGET = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_DECIDE,
    ST_RAMP,
    ST_ACCUM
  } state_e;

  typedef struct packed {
    logic [SpeedW-1:0] cruise_speed;
    logic [SpeedW-1:0] end_speed;
    logic [SpeedW-1:0] accel_step;
    logic [DistW-1:0]  target_distance;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic square;
    logic decide;
    logic ramp;
    logic accum;
  } cmd_t;

endpackage

/* src/trapezoidal_speed_profile_top.sv */
// Trapezoidal speed profile generator, one control tick per input word.
// Input channel: in_valid_i / in_stall_o carry restart_i; a 1 starts a new
// move (distance cleared, ride phase, cruise goal) before the tick is computed.
// Output channel: out_valid_o / out_stall_i carry speed_now_o, distance_done_o
// and phase_o (0 ride, 1 braking, 2 stop), one result word per input word.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 cruise speed, 1 end speed, 2 accel step, 3 target distance); write only
// while no tick is in flight.
// The result word is registered once the tick has walked all its steps.
// The tick walks a four-step sequencer: square and product (two parallel
// multipliers for the braking test), phase decision, speed ramp, distance add.
// A new word is not taken while a tick is in flight or its result waits;
// the next word is taken only in the cycle after the result word leaves.
// A stalled result holds its value and the input side stays stalled until
// the result word is taken.
// Reset puts the block in the stop phase with zero speed, goal and distance;
// the configuration registers clear to 0 except accel step, which resets to 1.
module trapezoidal_speed_profile_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           restart_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tsp_pkg::SpeedW-1:0]     speed_now_o,
  output logic [tsp_pkg::DistW-1:0]      distance_done_o,
  output logic [1:0]                     phase_o,
  input  logic                           cfg_we_i,
  input  logic [tsp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tsp_pkg::DistW-1:0]      cfg_data_i
);

  tsp_pkg::cfg_t cfg_q;
  tsp_pkg::cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cruise_speed    <= '0;
      cfg_q.end_speed       <= '0;
      cfg_q.accel_step      <= tsp_pkg::SpeedW'(1);
      cfg_q.target_distance <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tsp_pkg::CFG_CRUISE: cfg_q.cruise_speed    <= cfg_data_i[tsp_pkg::SpeedW-1:0];
        tsp_pkg::CFG_END:    cfg_q.end_speed       <= cfg_data_i[tsp_pkg::SpeedW-1:0];
        tsp_pkg::CFG_ACCEL:  cfg_q.accel_step      <= cfg_data_i[tsp_pkg::SpeedW-1:0];
        tsp_pkg::CFG_TARGET: cfg_q.target_distance <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  tsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  tsp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .restart_i   (restart_i),
    .speed_o     (speed_now_o),
    .travelled_o (distance_done_o),
    .phase_o     (phase_o)
  );

  // A pending result keeps the input side closed.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted while a result is pending");

  // No result can show up in the cycle right after an accept.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !out_valid_o)
    else $error("result appeared too early");

  // Exactly one result per word: a taken result is not shown again.
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |=> !out_valid_o)
    else $error("result repeated");

endmodule

/* src/tsp_ctrl.sv */
module tsp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tsp_pkg::cmd_t cmd_o
);

  tsp_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tsp_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    // A new word is taken only once the previous result has left.
    in_stall_o  = (state_q != tsp_pkg::ST_IDLE) || out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      tsp_pkg::ST_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          cmd_o.start = 1'b1;
          state_d     = tsp_pkg::ST_SQUARE;
        end
      end
      tsp_pkg::ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = tsp_pkg::ST_DECIDE;
      end
      tsp_pkg::ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = tsp_pkg::ST_RAMP;
      end
      tsp_pkg::ST_RAMP: begin
        cmd_o.ramp = 1'b1;
        state_d    = tsp_pkg::ST_ACCUM;
      end
      tsp_pkg::ST_ACCUM: begin
        cmd_o.accum = 1'b1;
        out_valid_d = 1'b1;
        state_d     = tsp_pkg::ST_IDLE;
      end
      default: begin
        state_d = tsp_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

/* src/tsp_dp.sv */
module tsp_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tsp_pkg::cfg_t               cfg_i,
  input  tsp_pkg::cmd_t               cmd_i,
  input  logic                        restart_i,
  output logic [tsp_pkg::SpeedW-1:0]  speed_o,
  output logic [tsp_pkg::DistW-1:0]   travelled_o,
  output logic [1:0]                  phase_o
);

  tsp_pkg::phase_e                 phase_q;
  logic [tsp_pkg::SpeedW-1:0]      speed_q, goal_q;
  logic [tsp_pkg::DistW-1:0]       travelled_q;
  logic [tsp_pkg::SqW-1:0]         sq_q;
  logic [tsp_pkg::ProdW-1:0]       prod_q;
  logic                            rem_pos_q, rem_big_q, arrive_q;

  logic [tsp_pkg::SpeedW-1:0]      diff, accel_eff, down;
  logic [tsp_pkg::DivW-1:0]        div_val, up;
  logic [tsp_pkg::DistW:0]         remain, dist_sum;
  logic [tsp_pkg::SqW-1:0]         sq_d;
  logic [tsp_pkg::ProdW-1:0]       prod_d;
  logic                            brake;
  logic [tsp_pkg::SpeedW-1:0]      speed_d;

  assign diff      = (speed_q >= cfg_i.end_speed) ? speed_q - cfg_i.end_speed
                                                  : cfg_i.end_speed - speed_q;
  assign accel_eff = (cfg_i.accel_step == '0) ? tsp_pkg::SpeedW'(1) : cfg_i.accel_step;
  assign div_val   = {accel_eff, 1'b0};
  assign remain    = {1'b0, cfg_i.target_distance} - {1'b0, travelled_q};
  assign sq_d      = {{tsp_pkg::SpeedW{1'b0}}, diff} * {{tsp_pkg::SpeedW{1'b0}}, diff};
  assign prod_d    = {{tsp_pkg::DivW{1'b0}}, remain[tsp_pkg::SqW-1:0]}
                   * {{tsp_pkg::SqW{1'b0}}, div_val};

  // floor(sq / div) >= remain is the same as sq >= remain * div for a positive remain.
  assign brake = !rem_pos_q ||
                 (!rem_big_q && ({{tsp_pkg::DivW{1'b0}}, sq_q} >= prod_q));

  assign up   = {1'b0, speed_q} + {1'b0, cfg_i.accel_step};
  assign down = speed_q - cfg_i.accel_step;

  always_comb begin
    speed_d = speed_q;
    if (speed_q < goal_q) begin
      speed_d = (up > {1'b0, goal_q}) ? goal_q : up[tsp_pkg::SpeedW-1:0];
    end else if (speed_q > goal_q) begin
      if (cfg_i.accel_step > speed_q || down < goal_q) begin
        speed_d = goal_q;
      end else begin
        speed_d = down;
      end
    end
  end

  assign dist_sum = {1'b0, travelled_q} + {{(tsp_pkg::DistW + 1 - tsp_pkg::SpeedW){1'b0}}, speed_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= tsp_pkg::PH_STOP;
      speed_q     <= '0;
      goal_q      <= '0;
      travelled_q <= '0;
    end else begin
      if (cmd_i.start && restart_i) begin
        travelled_q <= '0;
        phase_q     <= tsp_pkg::PH_RIDE;
        goal_q      <= cfg_i.cruise_speed;
      end
      if (cmd_i.decide) begin
        if (arrive_q) begin
          phase_q <= tsp_pkg::PH_STOP;
          goal_q  <= cfg_i.end_speed;
        end else if (phase_q == tsp_pkg::PH_RIDE && brake) begin
          phase_q <= tsp_pkg::PH_BRAKE;
          goal_q  <= cfg_i.end_speed;
        end
      end
      if (cmd_i.ramp) begin
        speed_q <= speed_d;
      end
      if (cmd_i.accum) begin
        travelled_q <= dist_sum[tsp_pkg::DistW] ? tsp_pkg::DistMax
                                                : dist_sum[tsp_pkg::DistW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) begin
      sq_q      <= sq_d;
      prod_q    <= prod_d;
      rem_pos_q <= cfg_i.target_distance > travelled_q;
      rem_big_q <= |remain[tsp_pkg::DistW-1:tsp_pkg::SqW];
      arrive_q  <= travelled_q >= cfg_i.target_distance;
    end
  end

  assign speed_o     = speed_q;
  assign travelled_o = travelled_q;
  assign phase_o     = phase_q;

endmodule

/* tb/sv/tb.sv */
module tb;

  typedef struct packed {
    logic [tsp_pkg::SpeedW-1:0] speed;
    logic [tsp_pkg::DistW-1:0]  distance;
    logic [1:0]                 phase;
  } tick_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic                        restart_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [tsp_pkg::SpeedW-1:0]  speed_now_o;
  logic [tsp_pkg::DistW-1:0]   distance_done_o;
  logic [1:0]                  phase_o;
  logic                        cfg_we_i = 1'b0;
  logic [tsp_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [tsp_pkg::DistW-1:0]   cfg_data_i = '0;

  trapezoidal_speed_profile_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .restart_i       (restart_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .speed_now_o     (speed_now_o),
    .distance_done_o (distance_done_o),
    .phase_o         (phase_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Mirror of the registers and the motion state, at their reset values.
  logic [tsp_pkg::SpeedW-1:0] cruise_q = '0;
  logic [tsp_pkg::SpeedW-1:0] end_q = '0;
  logic [tsp_pkg::SpeedW-1:0] accel_q = 12'd1;
  logic [tsp_pkg::DistW-1:0]  target_q = '0;
  tsp_pkg::phase_e            phase_q = tsp_pkg::PH_STOP;
  logic [tsp_pkg::SpeedW-1:0] speed_q = '0;
  logic [tsp_pkg::SpeedW-1:0] goal_q = '0;
  logic [tsp_pkg::DistW-1:0]  dist_q = '0;

  tick_t       ticks_q[$];
  int unsigned errors = 0;
  int unsigned words_sent = 0;
  bit          steady = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic tick_t advance_profile(input logic restart);
    longint unsigned          diff;
    longint unsigned          div;
    longint                   need;
    longint                   remain;
    logic [tsp_pkg::SpeedW:0] sum;
    logic [tsp_pkg::DistW:0]  dsum;
    tick_t                    res;
    if (restart) begin
      dist_q  = '0;
      phase_q = tsp_pkg::PH_RIDE;
      goal_q  = cruise_q;
    end
    if (phase_q == tsp_pkg::PH_RIDE) begin
      diff = (speed_q >= end_q) ? speed_q - end_q : end_q - speed_q;
      div = (accel_q == '0) ? 2 : 2 * accel_q;
      need = longint'((diff * diff) / div);
      // Past the target the remaining distance is negative, so this always brakes.
      remain = longint'(target_q) - longint'(dist_q);
      if (need >= remain) begin
        phase_q = tsp_pkg::PH_BRAKE;
        goal_q  = end_q;
      end
    end
    if (dist_q >= target_q) begin
      phase_q = tsp_pkg::PH_STOP;
      goal_q  = end_q;
    end
    if (speed_q < goal_q) begin
      sum = speed_q + accel_q;
      speed_q = (sum > goal_q) ? goal_q : sum[tsp_pkg::SpeedW-1:0];
    end else if (speed_q > goal_q) begin
      if (accel_q > speed_q || speed_q - accel_q < goal_q) begin
        speed_q = goal_q;
      end else begin
        speed_q = speed_q - accel_q;
      end
    end
    dsum = dist_q + speed_q;
    dist_q = (dsum > tsp_pkg::DistMax) ? tsp_pkg::DistMax : dsum[tsp_pkg::DistW-1:0];
    res.speed    = speed_q;
    res.distance = dist_q;
    res.phase    = phase_q;
    return res;
  endfunction

  task automatic send_word(input logic restart);
    while (!steady && $urandom_range(99) < 22) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (in_stall_o);
    ticks_q.push_back(advance_profile(restart));
    words_sent++;
  endtask

  // Holds the sender off until every result word is back and the block is quiet.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (ticks_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(input tsp_pkg::cfg_idx_e idx,
                           input logic [tsp_pkg::DistW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tsp_pkg::CFG_CRUISE: cruise_q = value[tsp_pkg::SpeedW-1:0];
      tsp_pkg::CFG_END:    end_q    = value[tsp_pkg::SpeedW-1:0];
      tsp_pkg::CFG_ACCEL:  accel_q  = value[tsp_pkg::SpeedW-1:0];
      tsp_pkg::CFG_TARGET: target_q = value;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_profile(input int unsigned cruise, input int unsigned stop_speed,
                             input int unsigned accel, input int unsigned target);
    drain();
    cfg_write(tsp_pkg::CFG_CRUISE, tsp_pkg::DistW'(cruise));
    cfg_write(tsp_pkg::CFG_END, tsp_pkg::DistW'(stop_speed));
    cfg_write(tsp_pkg::CFG_ACCEL, tsp_pkg::DistW'(accel));
    cfg_write(tsp_pkg::CFG_TARGET, tsp_pkg::DistW'(target));
  endtask

  task automatic run_move(input int max_ticks);
    int n;
    n = 0;
    send_word(1'b1);
    while (phase_q != tsp_pkg::PH_STOP && n < max_ticks) begin
      send_word(1'b0);
      n++;
    end
  endtask

  task automatic check_field(input string field, input logic [tsp_pkg::DistW-1:0] want,
                             input logic [tsp_pkg::DistW-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t %s expected %0d actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    tick_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (ticks_q.size() == 0) begin
        errors++;
        $display("%0t result word expected none actual speed %0d distance %0d phase %0d",
                 $time, speed_now_o, distance_done_o, phase_o);
      end else begin
        want = ticks_q.pop_front();
        check_field("speed_now", tsp_pkg::DistW'(want.speed),
                    tsp_pkg::DistW'(speed_now_o));
        check_field("distance_done", want.distance, distance_done_o);
        check_field("phase", tsp_pkg::DistW'(want.phase), tsp_pkg::DistW'(phase_o));
      end
    end
    out_stall_i <= !steady && ($urandom_range(99) < 22);
  end

  function automatic int unsigned rand_speed();
    case ($urandom_range(5))
      0: return 0;
      1: return 4095;
      default: return $urandom_range(4095);
    endcase
  endfunction

  task automatic test_reset_state();
    // Registers at reset: target zero, so a restart stops at once.
    send_word(1'b0);
    send_word(1'b0);
    send_word(1'b1);
  endtask

  task automatic test_ramp_and_brake();
    // The ramp-up step would overshoot the cruise speed and the braking step the end speed; both clamp.
    set_profile(100, 15, 30, 600);
    run_move(20);
    send_word(1'b0);
    send_word(1'b0);
  endtask

  task automatic test_restart_mid_move();
    set_profile(500, 0, 50, 20000);
    send_word(1'b1);
    repeat (4) send_word(1'b0);
    send_word(1'b1);
    send_word(1'b0);
  endtask

  task automatic test_zero_accel();
    set_profile(300, 0, 0, 5000);
    send_word(1'b1);
    repeat (3) send_word(1'b0);
  endtask

  task automatic test_past_target();
    set_profile(200, 200, 64, 1000000);
    send_word(1'b1);
    repeat (3) send_word(1'b0);
    drain();
    cfg_write(tsp_pkg::CFG_TARGET, tsp_pkg::DistW'(10));
    send_word(1'b0);
    send_word(1'b0);
  endtask

  task automatic test_extremes();
    set_profile(4095, 0, 4095, tsp_pkg::DistMax);
    send_word(1'b1);
    send_word(1'b0);
    drain();
    cfg_write(tsp_pkg::CFG_TARGET, '0);
    cfg_write(tsp_pkg::CFG_ACCEL, tsp_pkg::DistW'(4000));
    // The second step down is larger than the speed left and must clamp at zero.
    send_word(1'b0);
    send_word(1'b0);
  endtask

  task automatic test_long_cruise();
    // A long run at full speed with no idling on either side.
    set_profile(4095, 4095, 4095, tsp_pkg::DistMax);
    steady = 1'b1;
    send_word(1'b1);
    repeat (150) send_word(1'b0);
    steady = 1'b0;
  endtask

  task automatic test_random_moves(input int unsigned count);
    int unsigned first;
    int unsigned cruise;
    int unsigned accel;
    int unsigned target;
    first = words_sent;
    while (words_sent - first < count) begin
      if ($urandom_range(3) != 0) begin
        cruise = rand_speed();
        case ($urandom_range(9))
          0: accel = 0;
          1: accel = 4095;
          2, 3, 4: accel = $urandom_range(1, 32);
          default: accel = $urandom_range(1, 4095);
        endcase
        case ($urandom_range(7))
          0: target = 0;
          1: target = $urandom_range(tsp_pkg::DistMax);
          default: target = cruise * $urandom_range(1, 25) + $urandom_range(4095);
        endcase
        set_profile(cruise, rand_speed(), accel, target);
      end else if ($urandom_range(3) == 0) begin
        drain();
      end
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 10)) send_word(1'($urandom_range(1)));
      end else begin
        run_move($urandom_range(10, 80));
        repeat ($urandom_range(3)) send_word(1'b0);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_ramp_and_brake();
    test_restart_mid_move();
    test_zero_accel();
    test_past_target();
    test_extremes();
    test_long_cruise();
    test_random_moves(1350);
    drain();
    if (errors == 0) begin
      $display("[trapezoidal_speed_profile_top] OK");
    end else begin
      $display("[trapezoidal_speed_profile_top] ERROR");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("[trapezoidal_speed_profile_top] ERROR");
    $finish;
  end

endmodule
